[rtl/core/sha1c_pkg.sv]
// SHA-1 compression package: widths, round constants, initial chaining value,
// rotate helpers and the control structs shared by the core modules.
// No dependencies.
package sha1c_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int CHAIN_WORDS = 5;
  localparam int ROUND_W     = 7;
  localparam int COUNT_W     = 4;
  localparam int INDEX_W     = 3;

  typedef logic [WORD_W-1:0]                     word_t;
  typedef logic [ROUND_W-1:0]                    round_t;
  typedef logic [INDEX_W-1:0]                    index_t;
  typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0]    chain_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]    block_t;

  // Index 0 sits in the low slot
  localparam chain_t INIT_CHAIN = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam round_t ROUND_P1   = 7'd20;
  localparam round_t ROUND_P2   = 7'd40;
  localparam round_t ROUND_P3   = 7'd60;
  localparam round_t ROUND_LAST = 7'(ROUNDS - 1);
  localparam index_t INDEX_LAST = 3'(CHAIN_WORDS - 1);

  // Schedule control: load shifts a message word in, step shifts an expanded word in
  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  // Round unit control
  typedef struct packed {
    logic   load;
    logic   step;
    round_t round;
  } round_ctrl_t;

  function automatic word_t rotl1(input word_t v);
    return {v[WORD_W-2:0], v[WORD_W-1]};
  endfunction

  function automatic word_t rotl5(input word_t v);
    return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
  endfunction

  function automatic word_t rotl30(input word_t v);
    return {v[1:0], v[WORD_W-1:2]};
  endfunction

  // Additive constant for the round phase
  function automatic word_t round_k(input round_t r);
    word_t k;
    priority if (r < ROUND_P1) k = K0;
    else if (r < ROUND_P2)     k = K1;
    else if (r < ROUND_P3)     k = K2;
    else                       k = K3;
    return k;
  endfunction

endpackage

[rtl/core/sha1c_if.sv]
// Valid/ready channel interfaces for the SHA-1 compression core:
// message word input and digest word output. Depends on nothing.
interface sha1c_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        new_message;

  modport source(output valid, output message_word, output new_message, input ready);
  modport sink(input valid, input message_word, input new_message, output ready);
endinterface

interface sha1c_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        last_word;

  modport source(output valid, output digest_word, output digest_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input digest_index, input last_word,
               output ready);
endinterface

[rtl/core/sha1c_sched.sv]
// Message schedule: 16-word shift line that gathers the block, then expands
// one schedule word per round. Depends on sha1c_pkg.
module sha1c_sched
  import sha1c_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  word_t       word,
  output word_t       w_t
);

  // Slot 0 holds the oldest word, i.e. the schedule word of the current round
  block_t w;
  word_t  w_new;

  // Expand the next word from fixed taps
  assign w_new = rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);
  assign w_t   = w[0];

  // Shift in message words, then expanded words
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w <= {word, w[BLOCK_WORDS-1:1]};
    end else if (ctrl.step) begin
      w <= {w_new, w[BLOCK_WORDS-1:1]};
    end
  end

endmodule

[rtl/core/sha1c_round.sv]
// SHA-1 round unit: working registers a..e and one round datapath reused
// for all 80 rounds. Depends on sha1c_pkg.
module sha1c_round
  import sha1c_pkg::*;
(
  input  logic        clk,
  input  round_ctrl_t ctrl,
  input  chain_t      base,
  input  word_t       w_t,
  output chain_t      st
);

  word_t f;
  word_t tmp;

  // Select the round function by phase
  always_comb begin
    priority if (ctrl.round < ROUND_P1) f = (st[1] & st[2]) ^ (~st[1] & st[3]);
    else if (ctrl.round < ROUND_P2)     f = st[1] ^ st[2] ^ st[3];
    else if (ctrl.round < ROUND_P3)     f = (st[1] & st[2]) ^ (st[1] & st[3]) ^ (st[2] & st[3]);
    else                                f = st[1] ^ st[2] ^ st[3];
  end

  assign tmp = rotl5(st[0]) + f + st[4] + round_k(ctrl.round) + w_t;

  // Load the chaining value, then advance one round per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      st <= base;
    end else if (ctrl.step) begin
      st[4] <= st[3];
      st[3] <= st[2];
      st[2] <= rotl30(st[1]);
      st[1] <= st[0];
      st[0] <= tmp;
    end
  end

endmodule

[rtl/core/sha1_block_compression_top.sv]
// SHA-1 block compression top: word collection, round sequencer, chaining value, digest output.
// Sequence: after a block's 16th word, S_HOLD waits until any pending digest is taken and loads a..e;
// S_ROUND runs the 80 rounds on the shared round unit and S_ADD adds into the chaining value.
// Words are taken at one per cycle only in S_COLLECT, not while a block compresses; five digest beats follow.
// Reset: synchronous rst loads the initial chaining value and clears the word count.
// Depends on sha1c_pkg, sha1c_if, sha1c_sched and sha1c_round.
module sha1_block_compression_top
  import sha1c_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  sha1c_msg_if.sink          msg,
  sha1c_dig_if.source        dig
);

  typedef enum logic [1:0] {
    S_COLLECT,
    S_HOLD,
    S_ROUND,
    S_ADD
  } state_t;

  state_t                state;
  logic [COUNT_W-1:0]    word_count;
  logic [COUNT_W-1:0]    count_eff;
  logic                  restart;
  round_t                round;
  chain_t                cv;
  chain_t                base;
  chain_t                st;
  index_t                idx;
  logic                  out_valid;
  logic                  msg_fire;
  logic                  dig_fire;
  sched_ctrl_t           sched_ctrl;
  round_ctrl_t           round_ctrl;
  word_t                 w_t;
  word_t                 dig_word;

  assign msg.ready = (state == S_COLLECT);
  assign msg_fire  = msg.valid && msg.ready;
  assign dig_fire  = out_valid && dig.ready;

  // A flagged word starts a fresh block at position zero
  assign count_eff = msg.new_message ? '0 : word_count;
  assign base      = restart ? INIT_CHAIN : cv;

  assign sched_ctrl.load = msg_fire;
  assign sched_ctrl.step = (state == S_ROUND);

  assign round_ctrl.load  = (state == S_HOLD) && !out_valid;
  assign round_ctrl.step  = (state == S_ROUND);
  assign round_ctrl.round = round;

  sha1c_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .word (msg.message_word),
    .w_t  (w_t)
  );

  sha1c_round u_round (
    .clk  (clk),
    .ctrl (round_ctrl),
    .base (base),
    .w_t  (w_t),
    .st   (st)
  );

  // Select the chaining word for the current digest beat
  always_comb begin
    unique case (idx)
      3'd0:    dig_word = cv[0];
      3'd1:    dig_word = cv[1];
      3'd2:    dig_word = cv[2];
      3'd3:    dig_word = cv[3];
      3'd4:    dig_word = cv[4];
      default: dig_word = cv[0];
    endcase
  end

  assign dig.valid        = out_valid;
  assign dig.digest_word  = dig_word;
  assign dig.digest_index = idx;
  assign dig.last_word    = (idx == INDEX_LAST);

  // Sequencer, chaining value and digest beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      word_count <= '0;
      restart    <= 1'b0;
      round      <= '0;
      cv         <= INIT_CHAIN;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drain digest beats
      if (dig_fire) begin
        if (idx == INDEX_LAST) begin
          out_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end

      unique case (state)
        S_COLLECT: begin
          if (msg_fire) begin
            word_count <= count_eff + 4'd1;
            if (msg.new_message) begin
              restart <= 1'b1;
            end
            if (count_eff == 4'(BLOCK_WORDS - 1)) begin
              state <= S_HOLD;
            end
          end
        end
        // Wait until the previous digest is fully taken, then load a..e
        S_HOLD: begin
          if (!out_valid) begin
            if (restart) begin
              cv <= INIT_CHAIN;
            end
            restart <= 1'b0;
            round   <= '0;
            state   <= S_ROUND;
          end
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == ROUND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < CHAIN_WORDS; i++) begin
            cv[i] <= cv[i] + st[i];
          end
          out_valid <= 1'b1;
          idx       <= '0;
          state     <= S_COLLECT;
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // Digest beats never overlap the chaining value update
  a_no_add_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state != S_ADD))
    else $error("chaining value updated while digest beats pending");

  // Digest beats start only right after the final add
  a_out_after_add: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_ADD))
    else $error("digest valid rose without a finished compression");

  // Round counter stays in range while rounds run
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (round <= ROUND_LAST))
    else $error("round counter out of range");

  // A full block leaves the word count at zero
  a_count_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> (word_count == '0))
    else $error("word count not wrapped after a full block");

endmodule
